// ----- design/gsc_pkg.sv -----
// ----------------------------------------------------------------------------
// gsc_pkg: shared types, constants and arithmetic helpers
// Field widths, register codes and the Q2.14 normalisation and clamp
// functions used by the gamepad sample conditioner.
// ----------------------------------------------------------------------------
package gsc_pkg;

	localparam int CH_N        = 6;
	localparam int CH_W        = 3;
	localparam int VAL_W       = 16;
	localparam int BTN_W       = 12;
	localparam int RAW_W       = 8;
	localparam int PAD_FIELD_W = 2;
	localparam int LINK_W      = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int WIDE_W      = 18;

	// Reciprocals for the constant divisions: q = (m * R) >> RECIP_SHIFT is
	// exact for every 8-bit magnitude m.
	localparam int RECIP_SHIFT = 16;
	localparam logic [24:0] RECIP_MAIN = 25'd14913081; // 16384 / 72
	localparam logic [24:0] RECIP_SUB  = 25'd18199014; // 16384 / 59
	localparam logic [24:0] RECIP_TRIG = 25'd7158279;  // 16384 / 150

	typedef logic signed [VAL_W-1:0]  q14_t;
	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef q14_t [CH_N-1:0]          chan_vals_t;
	typedef logic [CH_N-1:0][RAW_W-1:0] raw_row_t;
	typedef logic [BTN_W-1:0]         btn_t;

	typedef enum logic [LINK_W-1:0] {
		LINK_OK    = 2'd0,
		LINK_NONE  = 2'd1,
		LINK_BUSY  = 2'd2,
		LINK_ERROR = 2'd3
	} link_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ABS_MIN = 2'd0,
		CFG_ABS_MAX = 2'd1,
		CFG_REL_MIN = 2'd2,
		CFG_REL_MAX = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		q14_t abs_min;
		q14_t abs_max;
		q14_t rel_min;
		q14_t rel_max;
	} limits_t;

	localparam q14_t ABS_MIN_RST = -16'sd16384;
	localparam q14_t ABS_MAX_RST = 16'sd16384;
	localparam q14_t REL_MIN_RST = -16'sd16384;
	localparam q14_t REL_MAX_RST = 16'sd16384;
	localparam wide_t DELTA_FLOOR = -18'sd32768;

	// Signed stick byte scaled to Q2.14, truncated toward zero.
	function automatic wide_t norm_stick(input logic [RAW_W-1:0] raw,
		input logic [24:0] recip);
		logic [RAW_W-1:0] mag;
		logic [32:0] prod;
		logic [16:0] q;
		wide_t pos;
		mag  = raw[RAW_W-1] ? (~raw + 8'd1) : raw;
		prod = {25'd0, mag} * {8'd0, recip};
		q    = prod[32:RECIP_SHIFT];
		pos  = $signed({1'b0, q});
		return raw[RAW_W-1] ? -pos : pos;
	endfunction

	// Unsigned trigger byte scaled to Q2.14, truncated.
	function automatic wide_t norm_trigger(input logic [RAW_W-1:0] raw);
		logic [32:0] prod;
		prod = {25'd0, raw} * {8'd0, RECIP_TRIG};
		return $signed({1'b0, prod[32:RECIP_SHIFT]});
	endfunction

	// Upper bound first, then lower: inverted limits yield the minimum.
	function automatic q14_t clamp_q14(input q14_t lo, input wide_t v, input q14_t hi);
		wide_t lo_x;
		wide_t hi_x;
		wide_t t;
		lo_x = WIDE_W'(lo);
		hi_x = WIDE_W'(hi);
		t    = (v < hi_x) ? v : hi_x;
		t    = (t > lo_x) ? t : lo_x;
		return VAL_W'(t);
	endfunction

endpackage

// ----- design/gsc_sample_if.sv -----
// ----------------------------------------------------------------------------
// gsc_sample_if: polled pad sample channel
// Valid/ready channel carrying one raw sample for one pad.
// ----------------------------------------------------------------------------
interface gsc_sample_if;
	import gsc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [PAD_FIELD_W-1:0]   pad_index;
	logic [LINK_W-1:0]        link_status;
	logic signed [RAW_W-1:0]  stick_x;
	logic signed [RAW_W-1:0]  stick_y;
	logic signed [RAW_W-1:0]  cstick_x;
	logic signed [RAW_W-1:0]  cstick_y;
	logic [RAW_W-1:0]         trigger_left;
	logic [RAW_W-1:0]         trigger_right;
	logic [BTN_W-1:0]         buttons;

	modport source (
		output valid, pad_index, link_status, stick_x, stick_y, cstick_x, cstick_y,
			trigger_left, trigger_right, buttons,
		input  ready
	);

	modport sink (
		input  valid, pad_index, link_status, stick_x, stick_y, cstick_x, cstick_y,
			trigger_left, trigger_right, buttons,
		output ready
	);

endinterface

// ----- design/gsc_result_if.sv -----
// ----------------------------------------------------------------------------
// gsc_result_if: conditioned channel result
// Valid/ready channel carrying one normalised axis or trigger result.
// ----------------------------------------------------------------------------
interface gsc_result_if;
	import gsc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [PAD_FIELD_W-1:0]   pad_number;
	logic [CH_W-1:0]          channel;
	logic signed [VAL_W-1:0]  absolute_value;
	logic signed [VAL_W-1:0]  relative_value;
	logic [BTN_W-1:0]         held_buttons;
	logic [BTN_W-1:0]         press_events;
	logic [BTN_W-1:0]         release_events;
	logic                     last;

	modport source (
		output valid, pad_number, channel, absolute_value, relative_value,
			held_buttons, press_events, release_events, last,
		input  ready
	);

	modport sink (
		input  valid, pad_number, channel, absolute_value, relative_value,
			held_buttons, press_events, release_events, last,
		output ready
	);

endinterface

// ----- design/gamepad_sample_conditioner_core.sv -----
// ----------------------------------------------------------------------------
// gamepad_sample_conditioner_core: pad sample conditioner top level
// A sample is taken into the input register in any cycle where that register
// is empty or draining. As it leaves the input register the link status
// updates the pad's present flag and, for a present pad, all six channels are
// normalised, clamped and latched with the button edges into the result
// register; a present pad's sample waits until the result register is free.
// The six results then leave one per cycle while the receiver is ready,
// channel 0 first, the last one flagged. The input register can take the next
// sample while earlier results are still leaving; samples for an absent or
// out-of-range pad produce no result. Limits must be written through the
// cfg port only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module gamepad_sample_conditioner_core #(
	parameter int NUM_PADS    = 4,
	parameter int NUM_BUTTONS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	gsc_sample_if.sink                         sample,
	gsc_result_if.source                       result,
	input  logic                               cfg_we,
	input  logic [gsc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gsc_pkg::VAL_W-1:0]          cfg_wdata
);
	import gsc_pkg::*;

	localparam int PAD_W    = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
	localparam int BTN_KEEP = (NUM_BUTTONS < BTN_W) ? NUM_BUTTONS : BTN_W;
	localparam logic [BTN_W-1:0] BTN_MASK = BTN_W'((1 << BTN_KEEP) - 1);
	localparam logic [CH_W-1:0]  LAST_BEAT = CH_W'(CH_N - 1);

	limits_t limits_q;

	// input register
	logic                   valid_s1;
	logic [PAD_FIELD_W-1:0] pad_s1;
	logic [LINK_W-1:0]      link_s1;
	raw_row_t               raw_s1;
	btn_t                   btn_s1;

	// per-pad state
	logic [NUM_PADS-1:0]    present_q;
	chan_vals_t             prev_q [NUM_PADS];
	btn_t                   held_q [NUM_PADS];

	// result register
	logic                   busy_q;
	logic [CH_W-1:0]        beat_q;
	logic [PAD_FIELD_W-1:0] pad_s2;
	chan_vals_t             abs_s2;
	chan_vals_t             rel_s2;
	btn_t                   held_s2;
	btn_t                   press_s2;
	btn_t                   release_s2;

	logic                   pad_ok;
	logic [PAD_W-1:0]       pad_idx;
	logic                   present_old;
	logic                   present_now;
	logic                   emit_s1;
	logic                   buf_free;
	logic                   take_s1;
	logic                   out_xfer;
	chan_vals_t             prev_row;
	btn_t                   old_btn;
	btn_t                   now_btn;
	chan_vals_t             abs_vals;
	chan_vals_t             rel_vals;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.abs_min <= ABS_MIN_RST;
			limits_q.abs_max <= ABS_MAX_RST;
			limits_q.rel_min <= REL_MIN_RST;
			limits_q.rel_max <= REL_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_ABS_MIN: limits_q.abs_min <= cfg_wdata;
				CFG_ABS_MAX: limits_q.abs_max <= cfg_wdata;
				CFG_REL_MIN: limits_q.rel_min <= cfg_wdata;
				CFG_REL_MAX: limits_q.rel_max <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign pad_ok  = 32'(pad_s1) < NUM_PADS;
	assign pad_idx = PAD_W'(pad_s1);

	always_comb begin
		present_old = 1'b0;
		prev_row    = '0;
		old_btn     = '0;
		if (pad_ok) begin
			present_old = present_q[pad_idx];
			prev_row    = prev_q[pad_idx];
			old_btn     = held_q[pad_idx];
		end
		case (link_t'(link_s1))
			LINK_OK:   present_now = 1'b1;
			LINK_NONE: present_now = 1'b0;
			default:   present_now = present_old;
		endcase
	end

	assign now_btn  = btn_s1 & BTN_MASK;
	assign emit_s1  = valid_s1 & pad_ok & present_now;
	assign out_xfer = busy_q & result.ready;
	assign buf_free = ~busy_q | (out_xfer & (beat_q == LAST_BEAT));
	assign take_s1  = valid_s1 & (~emit_s1 | buf_free);
	assign sample.ready = ~valid_s1 | take_s1;

	gsc_calc u_calc (
		.raw      (raw_s1),
		.prev     (prev_row),
		.limits   (limits_q),
		.abs_vals (abs_vals),
		.rel_vals (rel_vals)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			pad_s1  <= sample.pad_index;
			link_s1 <= sample.link_status;
			raw_s1  <= {sample.trigger_right, sample.trigger_left, sample.cstick_y,
				sample.cstick_x, sample.stick_y, sample.stick_x};
			btn_s1  <= sample.buttons;
		end
	end

	// commit pad state as the sample leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			for (int p = 0; p < NUM_PADS; p++) begin
				prev_q[p] <= '0;
				held_q[p] <= '0;
			end
		end else if (take_s1 && pad_ok) begin
			present_q[pad_idx] <= present_now;
			if (emit_s1) begin
				prev_q[pad_idx] <= abs_vals;
				held_q[pad_idx] <= now_btn;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			beat_q <= '0;
		end else begin
			if (out_xfer) begin
				if (beat_q == LAST_BEAT) begin
					busy_q <= 1'b0;
				end else begin
					beat_q <= beat_q + 1'b1;
				end
			end
			if (take_s1 && emit_s1) begin
				busy_q <= 1'b1;
				beat_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && emit_s1) begin
			pad_s2     <= pad_s1;
			abs_s2     <= abs_vals;
			rel_s2     <= rel_vals;
			held_s2    <= now_btn;
			press_s2   <= now_btn & ~old_btn;
			release_s2 <= old_btn & ~now_btn;
		end
	end

	assign result.valid          = busy_q;
	assign result.pad_number     = pad_s2;
	assign result.channel        = beat_q;
	assign result.absolute_value = abs_s2[beat_q];
	assign result.relative_value = rel_s2[beat_q];
	assign result.held_buttons   = held_s2;
	assign result.press_events   = press_s2;
	assign result.release_events = release_s2;
	assign result.last           = (beat_q == LAST_BEAT);

endmodule

// ----- design/gsc_calc.sv -----
// ----------------------------------------------------------------------------
// gsc_calc: per-channel normalisation and clamping
// Scales the four stick and two trigger bytes to Q2.14, applies the absolute
// limits (upper only for triggers) and forms the clamped delta against prev.
// ----------------------------------------------------------------------------
module gsc_calc (
	input  gsc_pkg::raw_row_t   raw,
	input  gsc_pkg::chan_vals_t prev,
	input  gsc_pkg::limits_t    limits,
	output gsc_pkg::chan_vals_t abs_vals,
	output gsc_pkg::chan_vals_t rel_vals
);
	import gsc_pkg::*;

	always_comb begin
		wide_t n;
		wide_t dd;
		q14_t  a;
		q14_t  pv;
		for (int c = 0; c < CH_N; c++) begin
			pv = prev[c];
			if (c < 4) begin
				n  = norm_stick(raw[c], (c < 2) ? RECIP_MAIN : RECIP_SUB);
				a  = clamp_q14(limits.abs_min, n, limits.abs_max);
				dd = WIDE_W'(a) - WIDE_W'(pv);
				rel_vals[c] = clamp_q14(limits.rel_min, dd, limits.rel_max);
			end else begin
				// triggers: upper clamps only, delta floored to the field range
				n  = norm_trigger(raw[c]);
				a  = (n > WIDE_W'(limits.abs_max)) ? limits.abs_max : VAL_W'(n);
				dd = WIDE_W'(a) - WIDE_W'(pv);
				if (dd > WIDE_W'(limits.rel_max)) begin
					dd = WIDE_W'(limits.rel_max);
				end
				if (dd < DELTA_FLOOR) begin
					dd = DELTA_FLOOR;
				end
				rel_vals[c] = VAL_W'(dd);
			end
			abs_vals[c] = a;
		end
	end

endmodule

// ----- tb/gamepad_sample_conditioner_core_test.sv -----
// ----------------------------------------------------------------------------
// gamepad_sample_conditioner_core_test: self-checking bench for the conditioner
// Drives pad samples over the sample channel and compares every conditioned
// channel result against a behavioural predictor of the normalisation, clamp,
// delta and button-edge logic, or hand-worked values where a row gives them.
// A short table of directed samples and limit writes runs first, then several
// random phases under different limits, random gaps and stalls in all but one.
// ----------------------------------------------------------------------------
module gamepad_sample_conditioner_core_test;
	import gsc_pkg::*;

	localparam int PADS    = 4;
	localparam int BUTTONS = 12;
	localparam btn_t BTN_MASK = btn_t'((1 << BUTTONS) - 1);
	localparam int RANDOM_SAMPLES = 80;
	localparam int PHASES = 5;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct {
		logic [PAD_FIELD_W-1:0]  pad;
		link_t                   link;
		logic signed [RAW_W-1:0] sx;
		logic signed [RAW_W-1:0] sy;
		logic signed [RAW_W-1:0] cx;
		logic signed [RAW_W-1:0] cy;
		logic [RAW_W-1:0]        tl;
		logic [RAW_W-1:0]        tr;
		btn_t                    btn;
	} pad_sample_t;

	typedef struct {
		row_kind_t   kind;
		pad_sample_t s;
		cfg_reg_t    reg_idx;
		int          reg_val;
		bit          typed;
		int          want_abs [CH_N];
		int          want_rel [CH_N];
	} stim_row_t;

	typedef struct {
		logic [PAD_FIELD_W-1:0] pad;
		logic [CH_W-1:0]        chan;
		q14_t                   abs_v;
		q14_t                   rel_v;
		btn_t                   held;
		btn_t                   press;
		btn_t                   rel_ev;
		logic                   last;
	} channel_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VAL_W-1:0] cfg_wdata;

	gsc_sample_if smp ();
	gsc_result_if res ();

	gamepad_sample_conditioner_core #(
		.NUM_PADS    (PADS),
		.NUM_BUTTONS (BUTTONS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (smp),
		.result    (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// predictor state
	bit   pad_live [PADS];
	int   prev_abs [PADS*CH_N];
	btn_t held_btn [PADS];
	int   lim_abs_min, lim_abs_max, lim_rel_min, lim_rel_max;

	channel_result_t batch [CH_N];
	channel_result_t due_results [$];
	stim_row_t       stim_table [$];
	int              mismatches;
	bit              steady;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#2000000;
		$display("gamepad_sample_conditioner_core_test: errors");
		$finish;
	end

	task automatic flag_error(input string msg);
		$display("ERROR %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			flag_error($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	function automatic int clamp_to(input int lo, input int v, input int hi);
		int t;
		t = (v < hi) ? v : hi;
		return (t > lo) ? t : lo;
	endfunction

	// Fill batch with the results of one accepted sample; return how many.
	function automatic int condition_sample(input pad_sample_t s);
		int raw_stick [4];
		int a, d, slot, raw;
		btn_t now_b, old_b;
		if (int'(s.pad) >= PADS)
			return 0;
		if (s.link == LINK_OK)
			pad_live[s.pad] = 1'b1;
		else if (s.link == LINK_NONE)
			pad_live[s.pad] = 1'b0;
		if (!pad_live[s.pad])
			return 0;
		raw_stick[0] = int'(s.sx);
		raw_stick[1] = int'(s.sy);
		raw_stick[2] = int'(s.cx);
		raw_stick[3] = int'(s.cy);
		now_b = s.btn & BTN_MASK;
		old_b = held_btn[s.pad];
		held_btn[s.pad] = now_b;
		for (int c = 0; c < CH_N; c++) begin
			slot = int'(s.pad) * CH_N + c;
			if (c < 4) begin
				a = raw_stick[c] * 16384 / ((c < 2) ? 72 : 59);
				a = clamp_to(lim_abs_min, a, lim_abs_max);
				d = clamp_to(lim_rel_min, a - prev_abs[slot], lim_rel_max);
			end else begin
				raw = (c == 4) ? int'(s.tl) : int'(s.tr);
				a = raw * 16384 / 150;
				if (a > lim_abs_max)
					a = lim_abs_max;
				d = a - prev_abs[slot];
				if (d > lim_rel_max)
					d = lim_rel_max;
				// saturate so the delta fits the field
				if (d < -32768)
					d = -32768;
			end
			prev_abs[slot] = a;
			batch[c].pad    = s.pad;
			batch[c].chan   = CH_W'(c);
			batch[c].abs_v  = q14_t'(a);
			batch[c].rel_v  = q14_t'(d);
			batch[c].held   = now_b;
			batch[c].press  = now_b & ~old_b;
			batch[c].rel_ev = old_b & ~now_b;
			batch[c].last   = (c == CH_N - 1);
		end
		return CH_N;
	endfunction

	function automatic void add_sample(input int pad, input link_t link, input int sx,
		input int sy, input int cx, input int cy, input int tl, input int tr, input int btn);
		stim_row_t r;
		r.kind    = ROW_SAMPLE;
		r.reg_idx = CFG_ABS_MIN;
		r.reg_val = 0;
		r.typed   = 1'b0;
		r.s.pad   = pad[1:0];
		r.s.link  = link;
		r.s.sx    = sx[7:0];
		r.s.sy    = sy[7:0];
		r.s.cx    = cx[7:0];
		r.s.cy    = cy[7:0];
		r.s.tl    = tl[7:0];
		r.s.tr    = tr[7:0];
		r.s.btn   = btn[11:0];
		stim_table.push_back(r);
	endfunction

	function automatic void add_write(input cfg_reg_t idx, input int val);
		stim_row_t r;
		r.kind    = ROW_WRITE;
		r.reg_idx = idx;
		r.reg_val = val;
		r.typed   = 1'b0;
		r.s.pad   = '0;
		r.s.link  = LINK_OK;
		r.s.sx    = '0;
		r.s.sy    = '0;
		r.s.cx    = '0;
		r.s.cy    = '0;
		r.s.tl    = '0;
		r.s.tr    = '0;
		r.s.btn   = '0;
		stim_table.push_back(r);
	endfunction

	// Attach hand-worked values to the most recent sample row.
	function automatic void typed_want(input int a0, input int a1, input int a2,
		input int a3, input int a4, input int a5, input int r0, input int r1,
		input int r2, input int r3, input int r4, input int r5);
		stim_row_t r;
		r = stim_table.pop_back();
		r.typed = 1'b1;
		r.want_abs[0] = a0; r.want_abs[1] = a1; r.want_abs[2] = a2;
		r.want_abs[3] = a3; r.want_abs[4] = a4; r.want_abs[5] = a5;
		r.want_rel[0] = r0; r.want_rel[1] = r1; r.want_rel[2] = r2;
		r.want_rel[3] = r3; r.want_rel[4] = r4; r.want_rel[5] = r5;
		stim_table.push_back(r);
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int pick_limit();
		case ($urandom_range(0, 5))
			0: return -32768;
			1: return 32767;
			2: return 0;
			3: return ($urandom_range(0, 1) != 0) ? 16384 : -16384;
			default: return int'(q14_t'($urandom_range(0, 65535)));
		endcase
	endfunction

	function automatic logic [RAW_W-1:0] pick_stick();
		if ($urandom_range(0, 99) < 15) begin
			case ($urandom_range(0, 4))
				0: return 8'h80;
				1: return 8'h7F;
				2: return 8'h00;
				3: return 8'hFF;
				default: return 8'h01;
			endcase
		end
		return RAW_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [RAW_W-1:0] pick_trigger();
		if ($urandom_range(0, 99) < 15)
			return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
		return RAW_W'($urandom_range(0, 255));
	endfunction

	function automatic stim_row_t random_row();
		stim_row_t r;
		int k;
		r.kind    = ROW_SAMPLE;
		r.reg_idx = CFG_ABS_MIN;
		r.reg_val = 0;
		r.typed   = 1'b0;
		r.s.pad   = PAD_FIELD_W'($urandom_range(0, PADS - 1));
		k = $urandom_range(0, 99);
		// mostly healthy links so pads stay present; some drop presence, the rest hold it
		if (k < 70)
			r.s.link = LINK_OK;
		else if (k < 80)
			r.s.link = LINK_NONE;
		else if (k < 90)
			r.s.link = LINK_BUSY;
		else
			r.s.link = LINK_ERROR;
		r.s.sx = pick_stick();
		r.s.sy = pick_stick();
		r.s.cx = pick_stick();
		r.s.cy = pick_stick();
		r.s.tl = pick_trigger();
		r.s.tr = pick_trigger();
		k = $urandom_range(0, 99);
		if (k < 15)
			r.s.btn = '0;
		else if (k < 30)
			r.s.btn = '1;
		else
			r.s.btn = BTN_W'($urandom_range(0, 4095));
		return r;
	endfunction

	// Drop valid and hold until every expected result has come and the block
	// has had time to finish any sample that produces nothing.
	task automatic settle();
		@(negedge clk);
		smp.valid = 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input cfg_reg_t idx, input int val);
		settle();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = val[15:0];
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_ABS_MIN: lim_abs_min = int'(q14_t'(val));
			CFG_ABS_MAX: lim_abs_max = int'(q14_t'(val));
			CFG_REL_MIN: lim_rel_min = int'(q14_t'(val));
			CFG_REL_MAX: lim_rel_max = int'(q14_t'(val));
			default: ;
		endcase
	endtask

	task automatic push_sample(input stim_row_t row, output int n);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			smp.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		smp.pad_index     = row.s.pad;
		smp.link_status   = row.s.link;
		smp.stick_x       = row.s.sx;
		smp.stick_y       = row.s.sy;
		smp.cstick_x      = row.s.cx;
		smp.cstick_y      = row.s.cy;
		smp.trigger_left  = row.s.tl;
		smp.trigger_right = row.s.tr;
		smp.buttons       = row.s.btn;
		smp.valid         = 1'b1;
		@(posedge clk);
		while (smp.ready !== 1'b1)
			@(posedge clk);
		n = condition_sample(row.s);
		for (int c = 0; c < n; c++) begin
			if (row.typed) begin
				batch[c].abs_v = q14_t'(row.want_abs[c]);
				batch[c].rel_v = q14_t'(row.want_rel[c]);
			end
			due_results.push_back(batch[c]);
		end
	endtask

	// receiver: random stalls, none while steady
	initial begin
		int hold;
		int r;
		hold = 0;
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!steady && hold > 0) begin
				res.ready = 1'b0;
				hold--;
			end else begin
				res.ready = 1'b1;
				r = $urandom_range(0, 99);
				if (steady || r < 70)
					hold = 0;
				else if (r < 95)
					hold = $urandom_range(1, 3);
				else
					hold = $urandom_range(10, 30);
			end
		end
	end

	always @(posedge clk) begin
		channel_result_t w;
		if (res.valid === 1'b1 && res.ready === 1'b1) begin
			if (due_results.size() == 0) begin
				flag_error($sformatf("unexpected transfer pad %0d channel %0d",
					res.pad_number, res.channel));
			end else begin
				w = due_results.pop_front();
				check_field("pad_number", int'(res.pad_number), int'(w.pad));
				check_field("channel", int'(res.channel), int'(w.chan));
				check_field("absolute_value", int'(res.absolute_value), int'(w.abs_v));
				check_field("relative_value", int'(res.relative_value), int'(w.rel_v));
				check_field("held_buttons", int'(res.held_buttons), int'(w.held));
				check_field("press_events", int'(res.press_events), int'(w.press));
				check_field("release_events", int'(res.release_events), int'(w.rel_ev));
				check_field("last", int'(res.last), int'(w.last));
			end
		end
	end

	initial begin
		int n;
		int produced;
		stim_row_t row;

		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_ABS_MIN;
		cfg_wdata = '0;
		smp.valid = 1'b0;
		smp.pad_index = '0;
		smp.link_status = LINK_OK;
		smp.stick_x = '0;
		smp.stick_y = '0;
		smp.cstick_x = '0;
		smp.cstick_y = '0;
		smp.trigger_left = '0;
		smp.trigger_right = '0;
		smp.buttons = '0;
		mismatches = 0;
		steady = 1'b0;
		for (int i = 0; i < PADS; i++) begin
			pad_live[i] = 1'b0;
			held_btn[i] = '0;
		end
		for (int i = 0; i < PADS*CH_N; i++)
			prev_abs[i] = 0;
		lim_abs_min = int'(ABS_MIN_RST);
		lim_abs_max = int'(ABS_MAX_RST);
		lim_rel_min = int'(REL_MIN_RST);
		lim_rel_max = int'(REL_MAX_RST);

		// directed table
		add_sample(0, LINK_NONE, 0, 0, 0, 0, 0, 0, 0);
		add_sample(0, LINK_OK, 0, 0, 0, 0, 0, 0, 0);
		typed_want(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_sample(0, LINK_OK, 127, -128, 127, -128, 255, 255, 12'hFFF);
		typed_want(16384, -16384, 16384, -16384, 16384, 16384,
			16384, -16384, 16384, -16384, 16384, 16384);
		add_sample(0, LINK_OK, -128, 127, -128, 127, 0, 0, 12'h000);
		typed_want(-16384, 16384, -16384, 16384, 0, 0,
			-16384, 16384, -16384, 16384, -16384, -16384);
		add_sample(1, LINK_BUSY, 5, 5, 5, 5, 5, 5, 12'h001);
		add_sample(1, LINK_OK, 72, -72, 59, -59, 150, 0, 12'h5A5);
		typed_want(16384, -16384, 16384, -16384, 16384, 0,
			16384, -16384, 16384, -16384, 16384, 0);
		add_sample(1, LINK_ERROR, 1, -1, 1, -1, 1, 1, 12'hA5A);
		add_sample(1, LINK_NONE, 3, 3, 3, 3, 3, 3, 12'h003);
		add_sample(1, LINK_BUSY, 3, 3, 3, 3, 3, 3, 12'h003);
		add_sample(2, LINK_OK, 71, -71, 58, -58, 149, 254, 12'h800);
		add_sample(3, LINK_ERROR, 9, 9, 9, 9, 9, 9, 12'h009);
		add_sample(3, LINK_OK, 33, -17, 100, -100, 20, 200, 12'h001);
		add_write(CFG_ABS_MIN, -32768);
		add_write(CFG_ABS_MAX, 32767);
		add_write(CFG_REL_MIN, -32768);
		add_write(CFG_REL_MAX, 32767);
		add_sample(2, LINK_OK, 127, -128, 127, -128, 255, 255, 12'hFFF);
		// trigger delta from full scale down to the floor saturates
		add_write(CFG_ABS_MAX, -32768);
		add_sample(2, LINK_OK, 0, 0, 0, 0, 255, 255, 12'hFFF);
		// inverted limits give the minimum on sticks; triggers take the maximum
		add_write(CFG_ABS_MIN, 1000);
		add_write(CFG_ABS_MAX, -1000);
		add_write(CFG_REL_MIN, 5000);
		add_write(CFG_REL_MAX, -5000);
		add_sample(0, LINK_OK, 127, -128, 127, -128, 255, 0, 12'h0F0);
		typed_want(1000, 1000, 1000, 1000, -1000, -1000,
			5000, 5000, 5000, 5000, -5000, -5000);
		add_sample(0, LINK_OK, -40, 40, 13, -7, 99, 17, 12'h30C);
		typed_want(1000, 1000, 1000, 1000, -1000, -1000,
			5000, 5000, 5000, 5000, -5000, -5000);

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		foreach (stim_table[i]) begin
			if (stim_table[i].kind == ROW_WRITE)
				write_limit(stim_table[i].reg_idx, stim_table[i].reg_val);
			else
				push_sample(stim_table[i], n);
		end

		// random phases, each under its own limits
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					write_limit(CFG_ABS_MIN, int'(ABS_MIN_RST));
					write_limit(CFG_ABS_MAX, int'(ABS_MAX_RST));
					write_limit(CFG_REL_MIN, int'(REL_MIN_RST));
					write_limit(CFG_REL_MAX, int'(REL_MAX_RST));
				end
				1: begin
					write_limit(CFG_ABS_MIN, -32768);
					write_limit(CFG_ABS_MAX, 32767);
					write_limit(CFG_REL_MIN, -32768);
					write_limit(CFG_REL_MAX, 32767);
				end
				4: begin
					write_limit(CFG_ABS_MIN, -8192);
					write_limit(CFG_ABS_MAX, 8192);
					write_limit(CFG_REL_MIN, -2048);
					write_limit(CFG_REL_MAX, 2048);
				end
				default: begin
					write_limit(CFG_ABS_MIN, pick_limit());
					write_limit(CFG_ABS_MAX, pick_limit());
					write_limit(CFG_REL_MIN, pick_limit());
					write_limit(CFG_REL_MAX, pick_limit());
				end
			endcase
			steady = (phase == 2);
			produced = 0;
			while (produced < RANDOM_SAMPLES / PHASES) begin
				row = random_row();
				push_sample(row, n);
				if (n > 0) begin
					produced++;
					// hold the sender once mid-phase until the output drains
					if (phase == 1 && produced == RANDOM_SAMPLES / PHASES / 2)
						settle();
				end
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && due_results.size() == 0)
			$display("gamepad_sample_conditioner_core_test: clean");
		else
			$display("gamepad_sample_conditioner_core_test: errors");
		$finish;
	end

endmodule

// ----- files.f -----
design/gsc_pkg.sv
design/gsc_sample_if.sv
design/gsc_result_if.sv
design/gsc_calc.sv
design/gamepad_sample_conditioner_core.sv
tb/gamepad_sample_conditioner_core_test.sv
